// ===== design/chi_pkg.sv =====
// ----------------------------------------------------------------------------
// chi_pkg: shared types and constants for the coalesced hash insert block
// Holds the field widths, parameter defaults, controller states and the
// command and status bundles that pass between the controller and datapath.
// ----------------------------------------------------------------------------
package chi_pkg;

   // Default parameter values
   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int KEY_BITS_DEF    = 63;

   // Fixed port widths
   localparam int KEY_W   = 63;
   localparam int SIZE_W  = 11;
   localparam int SLOT_W  = 10;
   localparam int COUNT_W = 32;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

   // Controller states, one-hot
   typedef enum logic [11:0] {
      S_CLEAR       = 12'b0000_0000_0001,
      S_IDLE        = 12'b0000_0000_0010,
      S_DIV         = 12'b0000_0000_0100,
      S_HOME_RD     = 12'b0000_0000_1000,
      S_HOME_CHK    = 12'b0000_0001_0000,
      S_SCAN_RD     = 12'b0000_0010_0000,
      S_SCAN_CHK    = 12'b0000_0100_0000,
      S_WALK_RD     = 12'b0000_1000_0000,
      S_WALK_CHK    = 12'b0001_0000_0000,
      S_COMMIT_NEW  = 12'b0010_0000_0000,
      S_COMMIT_LINK = 12'b0100_0000_0000,
      S_DONE        = 12'b1000_0000_0000
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic clear_step;
      logic load_key;
      logic div_step;
      logic home_rd;
      logic home_store;
      logic scan_init;
      logic scan_rd;
      logic scan_dec;
      logic drop;
      logic walk_init;
      logic walk_rd;
      logic walk_adv;
      logic commit_new;
      logic commit_link;
      logic rsp_load;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic clear_last;
      logic div_last;
      logic home_occ;
      logic scan_free;
      logic scan_last;
      logic walk_end;
   } status_type;

endpackage

// ===== design/chi_ram.sv =====
// ----------------------------------------------------------------------------
// chi_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module chi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/chi_dpath.sv =====
// ----------------------------------------------------------------------------
// chi_dpath: datapath of the coalesced hash insert block
// Size register, bit-serial modulo unit, slot tables, scan and chain
// pointers, comparison counter and the result register.
// ----------------------------------------------------------------------------
module chi_dpath #(
   parameter int TABLE_DEPTH = chi_pkg::TABLE_DEPTH_DEF,
   parameter int KEY_BITS    = chi_pkg::KEY_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  chi_pkg::cmd_type             cmd,
   output chi_pkg::status_type          status,
   input  logic                         csr_wr_en,
   input  logic [chi_pkg::SIZE_W-1:0]   csr_table_size,
   input  logic [chi_pkg::KEY_W-1:0]    req_key,
   output logic [chi_pkg::SLOT_W-1:0]   rsp_stored_slot,
   output logic [chi_pkg::SLOT_W-1:0]   rsp_home_slot,
   output logic                         rsp_collided,
   output logic                         rsp_dropped,
   output logic [chi_pkg::COUNT_W-1:0]  rsp_comparison_total
);
   import chi_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int LINK_W = IDX_W + 1;
   localparam int SZ_W   = (LINK_W > SIZE_W) ? LINK_W : SIZE_W;
   localparam int CNT_W  = $clog2(KEY_BITS);

   localparam logic [LINK_W-1:0] CHAIN_END = LINK_W'(TABLE_DEPTH);

   // Configuration and counter
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [COUNT_W-1:0]  cmp_ff, cmp_in;
   logic [IDX_W-1:0]    clr_ff, clr_in;

   // Working registers
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [KEY_BITS-1:0] quo_ff, quo_in;
   logic [SZ_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]    div_cnt_ff, div_cnt_in;
   logic [IDX_W-1:0]    home_ff, home_in;
   logic [IDX_W-1:0]    ptr_ff, ptr_in;
   logic [IDX_W-1:0]    at_ff, at_in;
   logic [IDX_W-1:0]    res_stored_ff, res_stored_in;
   logic                res_collided_ff, res_collided_in;
   logic                res_dropped_ff, res_dropped_in;

   // Result register
   logic [SLOT_W-1:0]   out_stored_ff, out_stored_in;
   logic [SLOT_W-1:0]   out_home_ff, out_home_in;
   logic                out_collided_ff, out_collided_in;
   logic                out_dropped_ff, out_dropped_in;
   logic [COUNT_W-1:0]  out_total_ff, out_total_in;

   // Derived values
   logic [SZ_W-1:0]     eff_size;
   logic [SZ_W:0]       rem_sh;

   // Table ports
   logic                occ_wr_en, occ_wr_data, occ_rd_en, occ_rd_data;
   logic [IDX_W-1:0]    occ_wr_addr, occ_rd_addr;
   logic                link_wr_en;
   logic [IDX_W-1:0]    link_wr_addr;
   logic [LINK_W-1:0]   link_wr_data, link_rd_data;
   logic                key_wr_en;
   logic [IDX_W-1:0]    key_wr_addr;

   // Size zero acts as one, sizes above the table act as the table
   always_comb begin
      if (size_ff == '0) begin
         eff_size = SZ_W'(1);
      end else if (SZ_W'(size_ff) > SZ_W'(TABLE_DEPTH)) begin
         eff_size = SZ_W'(TABLE_DEPTH);
      end else begin
         eff_size = SZ_W'(size_ff);
      end
   end

   assign rem_sh = {rem_ff, quo_ff[KEY_BITS-1]};

   always_comb begin
      size_in         = size_ff;
      cmp_in          = cmp_ff;
      clr_in          = clr_ff;
      key_in          = key_ff;
      quo_in          = quo_ff;
      rem_in          = rem_ff;
      div_cnt_in      = div_cnt_ff;
      home_in         = home_ff;
      ptr_in          = ptr_ff;
      at_in           = at_ff;
      res_stored_in   = res_stored_ff;
      res_collided_in = res_collided_ff;
      res_dropped_in  = res_dropped_ff;
      out_stored_in   = out_stored_ff;
      out_home_in     = out_home_ff;
      out_collided_in = out_collided_ff;
      out_dropped_in  = out_dropped_ff;
      out_total_in    = out_total_ff;

      if (csr_wr_en) begin
         size_in = csr_table_size;
      end
      if (cmd.clear_step) begin
         clr_in = clr_ff + IDX_W'(1);
      end
      if (cmd.load_key) begin
         key_in     = req_key[KEY_BITS-1:0];
         quo_in     = req_key[KEY_BITS-1:0];
         rem_in     = '0;
         div_cnt_in = CNT_W'(KEY_BITS - 1);
      end
      // Restoring division, one quotient bit a cycle
      if (cmd.div_step) begin
         quo_in     = quo_ff << 1;
         div_cnt_in = div_cnt_ff - CNT_W'(1);
         if (rem_sh >= {1'b0, eff_size}) begin
            rem_in = SZ_W'(rem_sh - {1'b0, eff_size});
         end else begin
            rem_in = SZ_W'(rem_sh);
         end
      end
      if (cmd.home_rd) begin
         home_in = rem_ff[IDX_W-1:0];
      end
      if (cmd.home_store) begin
         res_stored_in   = home_ff;
         res_collided_in = 1'b0;
         res_dropped_in  = 1'b0;
      end
      if (cmd.scan_init) begin
         ptr_in          = IDX_W'(eff_size - SZ_W'(1));
         res_collided_in = 1'b1;
         res_dropped_in  = 1'b0;
      end
      if (cmd.scan_rd) begin
         cmp_in = cmp_ff + COUNT_W'(1);
      end
      if (cmd.scan_dec) begin
         ptr_in = ptr_ff - IDX_W'(1);
      end
      if (cmd.drop) begin
         res_stored_in  = '0;
         res_dropped_in = 1'b1;
      end
      if (cmd.walk_init) begin
         at_in = home_ff;
      end
      if (cmd.walk_adv) begin
         at_in = link_rd_data[IDX_W-1:0];
      end
      if (cmd.commit_new) begin
         res_stored_in = ptr_ff;
      end
      if (cmd.rsp_load) begin
         out_stored_in   = SLOT_W'(res_stored_ff);
         out_home_in     = SLOT_W'(home_ff);
         out_collided_in = res_collided_ff;
         out_dropped_in  = res_dropped_ff;
         out_total_in    = cmp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
         cmp_ff  <= '0;
         clr_ff  <= '0;
      end else begin
         size_ff <= size_in;
         cmp_ff  <= cmp_in;
         clr_ff  <= clr_in;
      end
      key_ff          <= key_in;
      quo_ff          <= quo_in;
      rem_ff          <= rem_in;
      div_cnt_ff      <= div_cnt_in;
      home_ff         <= home_in;
      ptr_ff          <= ptr_in;
      at_ff           <= at_in;
      res_stored_ff   <= res_stored_in;
      res_collided_ff <= res_collided_in;
      res_dropped_ff  <= res_dropped_in;
      out_stored_ff   <= out_stored_in;
      out_home_ff     <= out_home_in;
      out_collided_ff <= out_collided_in;
      out_dropped_ff  <= out_dropped_in;
      out_total_ff    <= out_total_in;
   end

   // Occupancy table port selection
   always_comb begin
      occ_wr_en   = cmd.clear_step | cmd.home_store | cmd.commit_new;
      occ_wr_data = ~cmd.clear_step;
      occ_wr_addr = ptr_ff;
      if (cmd.clear_step) begin
         occ_wr_addr = clr_ff;
      end else if (cmd.home_store) begin
         occ_wr_addr = home_ff;
      end
      occ_rd_en   = cmd.home_rd | cmd.scan_rd;
      occ_rd_addr = cmd.home_rd ? rem_ff[IDX_W-1:0] : ptr_ff;
   end

   // Link table port selection
   always_comb begin
      link_wr_en   = cmd.home_store | cmd.commit_new | cmd.commit_link;
      link_wr_addr = ptr_ff;
      link_wr_data = CHAIN_END;
      if (cmd.home_store) begin
         link_wr_addr = home_ff;
      end else if (cmd.commit_link) begin
         link_wr_addr = at_ff;
         link_wr_data = {1'b0, ptr_ff};
      end
   end

   assign key_wr_en   = cmd.home_store | cmd.commit_new;
   assign key_wr_addr = cmd.home_store ? home_ff : ptr_ff;

   chi_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_occ_ram (
      .clock   (clock),
      .wr_en   (occ_wr_en),
      .wr_addr (occ_wr_addr),
      .wr_data (occ_wr_data),
      .rd_en   (occ_rd_en),
      .rd_addr (occ_rd_addr),
      .rd_data (occ_rd_data)
   );

   chi_ram #(.WIDTH(LINK_W), .DEPTH(TABLE_DEPTH)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (cmd.walk_rd),
      .rd_addr (at_ff),
      .rd_data (link_rd_data)
   );

   // Key store: written unless dropped, read by nothing in this block
   chi_ram #(.WIDTH(KEY_BITS), .DEPTH(TABLE_DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (key_ff),
      .rd_en   (1'b0),
      .rd_addr (key_wr_addr),
      .rd_data ()
   );

   always_comb begin
      status.clear_last = (clr_ff == IDX_W'(TABLE_DEPTH - 1));
      status.div_last   = (div_cnt_ff == '0);
      status.home_occ   = occ_rd_data;
      status.scan_free  = ~occ_rd_data;
      status.scan_last  = (ptr_ff == '0);
      status.walk_end   = (link_rd_data >= CHAIN_END);
   end

   assign rsp_stored_slot      = out_stored_ff;
   assign rsp_home_slot        = out_home_ff;
   assign rsp_collided         = out_collided_ff;
   assign rsp_dropped          = out_dropped_ff;
   assign rsp_comparison_total = out_total_ff;

endmodule

// ===== design/chi_ctrl.sv =====
// ----------------------------------------------------------------------------
// chi_ctrl: controller of the coalesced hash insert block
// Sequences table clearing, the modulo, home check, slot scan, chain walk,
// table updates and the result handshake.
// ----------------------------------------------------------------------------
module chi_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  chi_pkg::status_type status,
   output chi_pkg::cmd_type    cmd
);
   import chi_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_key = 1'b1;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_HOME_RD;
            end
         end
         S_HOME_RD: begin
            cmd.home_rd = 1'b1;
            state_in    = S_HOME_CHK;
         end
         S_HOME_CHK: begin
            if (status.home_occ) begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN_RD;
            end else begin
               cmd.home_store = 1'b1;
               state_in       = S_DONE;
            end
         end
         S_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
            state_in    = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (status.scan_free) begin
               cmd.walk_init = 1'b1;
               state_in      = S_WALK_RD;
            end else if (status.scan_last) begin
               cmd.drop = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.scan_dec = 1'b1;
               state_in     = S_SCAN_RD;
            end
         end
         S_WALK_RD: begin
            cmd.walk_rd = 1'b1;
            state_in    = S_WALK_CHK;
         end
         S_WALK_CHK: begin
            if (status.walk_end) begin
               state_in = S_COMMIT_NEW;
            end else begin
               cmd.walk_adv = 1'b1;
               state_in     = S_WALK_RD;
            end
         end
         S_COMMIT_NEW: begin
            cmd.commit_new = 1'b1;
            state_in       = S_COMMIT_LINK;
         end
         S_COMMIT_LINK: begin
            cmd.commit_link = 1'b1;
            state_in        = S_DONE;
         end
         S_DONE: begin
            // Hold until the result register is free or being taken
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/coalesced_hash_insert.sv =====
// ----------------------------------------------------------------------------
// coalesced_hash_insert: coalesced-chained hash table insert unit
// Inserts keys into a table of TABLE_DEPTH slots, linking colliding keys
// at the tail of the home slot's chain, and reports each insert.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_valid/req_stall with the key on req_key; one
//   response per request leaves on rsp_valid/rsp_stall with the stored
//   slot, home slot, collision and drop flags and the running comparison
//   total. csr_wr_en writes csr_table_size (slots in use, 0 acts as 1,
//   values above TABLE_DEPTH act as TABLE_DEPTH); write it only while idle.
//   After reset the occupancy table is swept clear, one slot a cycle;
//   req_stall stays high during the sweep. One request is worked at a
//   time. The time from acceptance to the response being loaded is set
//   by the one-bit-a-cycle modulo unit when the home slot is free. On a
//   collision, time is added per slot scanned, per chain link followed
//   (tail included) and for the table update; the single read port of
//   each table sets these. A request is accepted at the earliest in the
//   cycle after the previous response is loaded. The response sits in an
//   output register, so the next request is taken while a stalled
//   response waits; its result is held until rsp_stall drops.
// ----------------------------------------------------------------------------
module coalesced_hash_insert #(
   parameter int TABLE_DEPTH = chi_pkg::TABLE_DEPTH_DEF,
   parameter int KEY_BITS    = chi_pkg::KEY_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [chi_pkg::SIZE_W-1:0]   csr_table_size,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [chi_pkg::KEY_W-1:0]    req_key,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [chi_pkg::SLOT_W-1:0]   rsp_stored_slot,
   output logic [chi_pkg::SLOT_W-1:0]   rsp_home_slot,
   output logic                         rsp_collided,
   output logic                         rsp_dropped,
   output logic [chi_pkg::COUNT_W-1:0]  rsp_comparison_total
);
   import chi_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer: clear sweep, modulo, home check, scan, chain walk, commit
   chi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Tables, modulo unit, pointers, counter and response register
   chi_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BITS    (KEY_BITS)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .csr_wr_en            (csr_wr_en),
      .csr_table_size       (csr_table_size),
      .req_key              (req_key),
      .rsp_stored_slot      (rsp_stored_slot),
      .rsp_home_slot        (rsp_home_slot),
      .rsp_collided         (rsp_collided),
      .rsp_dropped          (rsp_dropped),
      .rsp_comparison_total (rsp_comparison_total)
   );

endmodule
